### src/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int OFFSET_BITS_DEF = 24;

    localparam int PATTERN_REG_BYTES = 32;
    localparam int CARE_W = 32;
    localparam int LENGTH_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int PATTERN_WORDS = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0_7 = 3'd0,
        REG_PATTERN_8_15 = 3'd1,
        REG_PATTERN_16_23 = 3'd2,
        REG_PATTERN_24_31 = 3'd3,
        REG_CARE_BITS = 3'd4,
        REG_PATTERN_LENGTH = 3'd5
    } mbps_reg_t;

    typedef struct packed {
        logic emit;
        logic found;
    } mbps_res_t;

endpackage

### src/mbps_match_unit.sv
// Region state and parallel prefix-match logic for one scanned byte per step.
module mbps_match_unit #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           step,
    input  logic [7:0]                                     data_byte,
    input  logic                                           is_last,
    input  logic [mbps_pkg::PATTERN_REG_BYTES-1:0][7:0]    pattern,
    input  logic [mbps_pkg::CARE_W-1:0]                    care_bits,
    input  logic [mbps_pkg::LENGTH_W-1:0]                  pattern_length,
    output mbps_pkg::mbps_res_t                            res,
    output logic [OFFSET_BITS-1:0]                         match_offset
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int SEEN_W = OFFSET_BITS + 1;
    localparam int SUM_W = SEEN_W + 1;
    localparam logic [SEEN_W-1:0] SEEN_LIMIT =
        SEEN_W'((64'(1) << OFFSET_BITS) + 64'(PATTERN_MAX));
    localparam logic [SEEN_W-1:0] OFFSET_LIMIT =
        SEEN_W'((64'(1) << OFFSET_BITS) - 64'(1));

    logic [PATTERN_MAX-1:0] prefix_reg;
    logic [PATTERN_MAX-1:0] prefix_next;
    logic [SEEN_W-1:0]      seen_reg;
    logic [SEEN_W-1:0]      seen_next;
    logic                   reported_reg;
    logic                   reported_next;

    logic [PATTERN_MAX-1:0] byte_ok;
    logic [PATTERN_MAX-1:0] len_sel;
    logic [LEN_W-1:0]       len_eff;
    logic [SEEN_W-1:0]      seen_inc;
    logic [SEEN_W-1:0]      offset_full;
    logic [SUM_W-1:0]       seen_bound;
    logic                   in_range;
    logic                   hit;

    // Bit k of the prefix vector is set when pattern bytes 0..k match the bytes
    // ending at the newest one.
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_byte
            if (k < PATTERN_REG_BYTES) begin : g_held
                assign byte_ok[k] = !care_bits[k] || (pattern[k] == data_byte);
            end
            else begin : g_wild
                assign byte_ok[k] = 1'b1;
            end
            if (k == 0) begin : g_first
                assign prefix_next[k] = byte_ok[k];
            end
            else begin : g_rest
                assign prefix_next[k] = prefix_reg[k-1] && byte_ok[k];
            end
            assign len_sel[k] = (len_eff == LEN_W'(k + 1));
        end
    endgenerate

    always_comb
    begin
        if (pattern_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (7'(pattern_length) > 7'(PATTERN_MAX))
        begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LEN_W'(pattern_length);
        end
    end

    assign seen_inc = (seen_reg < SEEN_LIMIT) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign seen_bound = SUM_W'(OFFSET_LIMIT) + SUM_W'(len_eff);
    assign in_range = (SUM_W'(seen_inc) <= seen_bound);
    assign offset_full = seen_inc - SEEN_W'(len_eff);
    assign hit = (|(prefix_next & len_sel)) && in_range;

    always_comb
    begin
        res.emit = !reported_reg && (hit || is_last);
        res.found = !reported_reg && hit;
        match_offset = (!reported_reg && hit) ? offset_full[OFFSET_BITS-1:0] : '0;
    end

    always_comb
    begin
        seen_next = seen_reg;
        reported_next = reported_reg;
        if (step)
        begin
            if (is_last)
            begin
                seen_next = '0;
                reported_next = 1'b0;
            end
            else if (!reported_reg)
            begin
                seen_next = seen_inc;
                reported_next = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            seen_reg <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                if (is_last)
                begin
                    prefix_reg <= '0;
                end
                else if (!reported_reg)
                begin
                    prefix_reg <= prefix_next;
                end
            end
            seen_reg <= seen_next;
            reported_reg <= reported_next;
        end
    end

endmodule

### src/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search: configuration, input and result registers.
//
// The block scans a region at one byte per cycle unless out_stall holds the result
// register; a byte goes to the s1 input register and its result to the output register.
// A prefix vector of PATTERN_MAX bits is updated for each processed byte against all
// pattern bytes compared in parallel with that byte, so the rate is set by that single compare
// and AND stage. A result (found with the offset of the first matching byte, or not
// found at the end of a region) appears at most once per region; bytes after a match
// are taken and dropped until the last byte of the region.
module masked_byte_pattern_search #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    input  logic                                 is_last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic [OFFSET_BITS-1:0]               match_offset
);
    import mbps_pkg::*;

    logic [PATTERN_WORDS-1:0][CFG_DATA_W-1:0] pattern_words_reg;
    logic [CARE_W-1:0]                        care_bits_reg;
    logic [LENGTH_W-1:0]                      pattern_length_reg;

    logic                   s1_valid_reg;
    logic [7:0]             s1_data_reg;
    logic                   s1_last_reg;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   s1_go;
    mbps_res_t              res;
    logic [OFFSET_BITS-1:0] res_offset;
    logic [PATTERN_REG_BYTES-1:0][7:0] pattern_bytes;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_fire = in_valid && !in_stall;
    assign pattern_bytes = pattern_words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_words_reg <= '0;
            care_bits_reg <= '0;
            pattern_length_reg <= LENGTH_W'(1);
        end
        else if (cfg_we)
        begin
            case (mbps_reg_t'(cfg_index))
                REG_PATTERN_0_7:    pattern_words_reg[0] <= cfg_data;
                REG_PATTERN_8_15:   pattern_words_reg[1] <= cfg_data;
                REG_PATTERN_16_23:  pattern_words_reg[2] <= cfg_data;
                REG_PATTERN_24_31:  pattern_words_reg[3] <= cfg_data;
                REG_CARE_BITS:      care_bits_reg <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LENGTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire || (s1_valid_reg && !s1_go);
            if (s1_go && res.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= is_last;
        end
        if (s1_go && res.emit)
        begin
            found_reg <= res.found;
            offset_reg <= res_offset;
        end
    end

    mbps_match_unit #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_go),
        .data_byte      (s1_data_reg),
        .is_last        (s1_last_reg),
        .pattern        (pattern_bytes),
        .care_bits      (care_bits_reg),
        .pattern_length (pattern_length_reg),
        .res            (res),
        .match_offset   (res_offset)
    );

    assign out_valid = out_valid_reg;
    assign found = found_reg;
    assign match_offset = offset_reg;

    a_rise_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_go))
        else $error("Result appeared without a processed item.");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |-> in_stall)
        else $error("Input taken while the result register is blocked.");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && res.emit && !res.found |-> res_offset == '0)
        else $error("Not-found result carries a nonzero offset.");

endmodule

### verif/tb_masked_byte_pattern_search.sv
// Self-checking testbench for the masked byte pattern search block.
module tb_masked_byte_pattern_search;
    import mbps_pkg::*;

    localparam int CYCLE = 12;
    localparam int PMAX = PATTERN_MAX_DEF;
    localparam int OFF_W = OFFSET_BITS_DEF;
    localparam longint unsigned OFFSET_MAX = (64'd1 << OFF_W) - 1;
    localparam longint unsigned SEEN_CAP = (64'd1 << OFF_W) + PMAX;
    localparam int TARGET_BYTES = 1650;
    localparam int QUIET_BYTES = 1400;

    typedef struct packed {
        logic found;
        logic [OFF_W-1:0] offset;
    } scan_result_t;

    class search_scoreboard;
        logic [63:0] pattern_word [PATTERN_WORDS];
        logic [CARE_W-1:0] care;
        logic [LENGTH_W-1:0] length_reg;
        logic [7:0] window [PMAX];
        longint unsigned seen;
        bit matched;
        scan_result_t pending_hits [$];
        int errors;
        int scanned;
        int regions;
        int found_checked;
        int miss_checked;

        function new();
            foreach (pattern_word[i]) pattern_word[i] = '0;
            care = '0;
            length_reg = 1;
            errors = 0;
            scanned = 0;
            regions = 0;
            found_checked = 0;
            miss_checked = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[i]) window[i] = '0;
            seen = 0;
            matched = 0;
        endfunction

        function void set_reg(mbps_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PATTERN_0_7, REG_PATTERN_8_15, REG_PATTERN_16_23, REG_PATTERN_24_31:
                    pattern_word[int'(idx)] = value;
                REG_CARE_BITS: care = value[CARE_W-1:0];
                REG_PATTERN_LENGTH: length_reg = value[LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_length();
            int n;
            n = length_reg;
            if (n == 0) n = 1;
            if (n > PMAX) n = PMAX;
            return n;
        endfunction

        function logic [7:0] pattern_byte(int k);
            return pattern_word[k >> 3][(k & 7) * 8 +: 8];
        endfunction

        function bit window_hit(int len);
            for (int k = 0; k < len; k++) begin
                if (k < PATTERN_REG_BYTES && care[k] && pattern_byte(k) != window[len - 1 - k])
                    return 0;
            end
            return 1;
        endfunction

        function void scan_byte(logic [7:0] data, logic last);
            int len;
            longint unsigned off;
            scanned++;
            if (!matched) begin
                len = active_length();
                for (int i = PMAX - 1; i > 0; i--) window[i] = window[i - 1];
                window[0] = data;
                if (seen < SEEN_CAP) seen++;
                if (seen >= len) begin
                    off = seen - len;
                    if (off <= OFFSET_MAX && window_hit(len)) begin
                        matched = 1;
                        pending_hits.push_back({1'b1, off[OFF_W-1:0]});
                    end
                end
                if (last && !matched) pending_hits.push_back({1'b0, {OFF_W{1'b0}}});
            end
            if (last) begin
                clear_region();
                regions++;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic got_found, logic [OFF_W-1:0] got_offset);
            scan_result_t want;
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          got_found, got_offset));
                return;
            end
            want = pending_hits.pop_front();
            if (want.found) found_checked++;
            else miss_checked++;
            if (got_found !== want.found)
                report_mismatch($sformatf("found is %0b, expected %0b", got_found, want.found));
            if (got_offset !== want.offset)
                report_mismatch($sformatf("match_offset is %0d, expected %0d",
                                          got_offset, want.offset));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [7:0] data_byte;
    logic is_last;
    logic out_valid;
    logic out_stall;
    logic found;
    logic [OFF_W-1:0] match_offset;

    search_scoreboard sb;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int settings_used = 0;

    masked_byte_pattern_search DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .is_last(is_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .match_offset(match_offset)
    );

    initial clk = 1'b0;
    always #(CYCLE / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.scan_byte(data_byte, is_last);
            if (out_valid && !out_stall) sb.check_result(found, match_offset);
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_byte(logic [7:0] data, logic last);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= data;
        is_last <= last;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (sb.pending_hits.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(mbps_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_setting(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                 logic [63:0] w3, logic [31:0] care_mask,
                                 logic [LENGTH_W-1:0] len);
        drain_pipeline();
        write_reg(REG_PATTERN_0_7, w0);
        write_reg(REG_PATTERN_8_15, w1);
        write_reg(REG_PATTERN_16_23, w2);
        write_reg(REG_PATTERN_24_31, w3);
        write_reg(REG_CARE_BITS, {32'd0, care_mask});
        write_reg(REG_PATTERN_LENGTH, {{(CFG_DATA_W - LENGTH_W){1'b0}}, len});
        settings_used++;
    endtask

    task automatic run_region(int rlen, bit plant, bit spoil);
        logic [7:0] bytes_q [$];
        int care_pos [$];
        int len;
        int pos;
        int pick;
        len = sb.active_length();
        for (int k = 0; k < rlen; k++)
        begin
            if ($urandom_range(0, 1))
                bytes_q.push_back(8'($urandom_range(0, 255)));
            else
                bytes_q.push_back(sb.pattern_byte($urandom_range(0, len - 1)));
        end
        if (plant && rlen >= len)
        begin
            pos = $urandom_range(0, rlen - len);
            for (int k = 0; k < len; k++)
            begin
                if (sb.care[k])
                begin
                    bytes_q[pos + k] = sb.pattern_byte(k);
                    care_pos.push_back(k);
                end
            end
            if (spoil && care_pos.size() != 0)
            begin
                pick = care_pos[$urandom_range(0, care_pos.size() - 1)];
                bytes_q[pos + pick] ^= 8'($urandom_range(1, 255));
            end
        end
        for (int k = 0; k < rlen; k++) send_byte(bytes_q[k], k == rlen - 1);
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [31:0] care_mask;
        logic [LENGTH_W-1:0] len;
        int rlen;
        int span;
        int waited;

        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PATTERN_0_7;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        is_last = 1'b0;
        out_stall = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: length one with every byte a wildcard.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b1);

        gap_pct = 20;
        stall_pct = 20;
        apply_setting(64'hFFFF_FFFF_FFFF_C35A, '1, '0, 64'h0123_4567_89AB_CDEF, 32'h3, 6'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h77, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h5A, 1'b1);

        // A length of zero acts as one; the match lands on the last byte.
        apply_setting(64'h5A, '0, '0, '0, 32'h1, 6'd0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h5A, 1'b1);

        // An oversized length saturates, so a short region cannot match.
        apply_setting('1, '1, '1, '1, 32'hFFFF_FFFF, 6'd63);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        while (sb.scanned < TARGET_BYTES)
        begin
            case ($urandom_range(0, 7))
                0: care_mask = '1;
                1: care_mask = '0;
                2: care_mask = $urandom & $urandom;
                3: care_mask = $urandom | $urandom;
                default: care_mask = $urandom;
            endcase
            case ($urandom_range(0, 11))
                0: len = 6'd1;
                1: len = 6'd32;
                2: len = 6'd0;
                3: len = 6'($urandom_range(33, 63));
                4, 5: len = 6'($urandom_range(9, 32));
                default: len = 6'($urandom_range(1, 8));
            endcase
            if (sb.scanned >= QUIET_BYTES)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            apply_setting(random_word(), random_word(), random_word(), random_word(),
                          care_mask, len);
            span = sb.active_length();
            repeat ($urandom_range(6, 20))
            begin
                if (sb.scanned < TARGET_BYTES)
                begin
                    case ($urandom_range(0, 9))
                        0: rlen = $urandom_range(1, 3);
                        1: rlen = $urandom_range(span + 20, span + 60);
                        default: rlen = $urandom_range(span > 2 ? span - 2 : 1, span + 12);
                    endcase
                    run_region(rlen, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
                end
            end
        end

        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending_hits.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (sb.pending_hits.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_hits.size()));

        $display("Scanned %0d bytes in %0d regions under %0d register settings.",
                 sb.scanned, sb.regions, settings_used);
        $display("Checked %0d found and %0d not-found results.",
                 sb.found_checked, sb.miss_checked);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #(CYCLE * 1500000);
        $display("Timed out waiting for the block.");
        $display("Regression FAIL");
        $finish;
    end

endmodule
